// ===== hw/rtl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// shared widths, codes and controller/datapath types of the slot allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int CMD_W         = 3;
	localparam int IDX_W         = 10;
	localparam int CNT_W         = 11;
	localparam int STAT_W        = 2;
	localparam int WORD_W        = 32;
	localparam int WORD_SH       = $clog2(WORD_W);
	localparam int DEF_MAX_SLOTS = 1024;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CMD_W-1:0] CMD_FIND      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MARK_USED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK_FREE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_SLOT_RD,
		S_SLOT_EXEC,
		S_MISC
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_NEXT,
		RD_SLOT
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_FULL,
		RES_FIND,
		RES_SLOT,
		RES_MISC
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      scan_clr;
		logic      scan_inc;
		logic      load;
		res_kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] in_cmd;
		logic             full;
		logic             hit;
		logic             last;
	} ctrl_stat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [IDX_W-1:0]  free_slot;
		logic              slot_used;
		logic [CNT_W-1:0]  used_count;
	} result_t;

endpackage

// ===== hw/rtl/bsa_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_cmd_if
// command channel of the slot allocator: valid/ready with command payload
// ----------------------------------------------------------------------------
interface bsa_cmd_if import bsa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] slot_index;

	modport source (output valid, output command, output slot_index, input ready);
	modport sink (input valid, input command, input slot_index, output ready);
endinterface

// ===== hw/rtl/bsa_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_res_if
// result channel of the slot allocator: valid/ready with result payload
// ----------------------------------------------------------------------------
interface bsa_res_if import bsa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              found;
	logic [IDX_W-1:0]  free_slot;
	logic              slot_used;
	logic [CNT_W-1:0]  used_count;

	modport source (
		output valid, output status, output found, output free_slot,
		output slot_used, output used_count, input ready
	);
	modport sink (
		input valid, input status, input found, input free_slot,
		input slot_used, input used_count, output ready
	);
endinterface

// ===== hw/rtl/bitmap_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// one-bit-per-slot occupancy allocator with used count and capacity register
// ----------------------------------------------------------------------------
// sequence: mark, free and query read the slot's word, then load the result,
// mark and free also writing the word; clear all, unknown commands and find on
// a full count load the result directly; otherwise find reads the 32-slot words
// in turn and loads at the first free slot or the last word; every result load
// waits for a free result output; one transaction at a time, accepted in idle
// reset: capacity 1024, map and count clear at once through per-word valid flags
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core import bsa_pkg::*; #(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	bsa_cmd_if.sink            cmd,
	bsa_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ctrl_cmd_t        ctl;
	ctrl_stat_t       st;
	result_t          result;
	logic [CNT_W-1:0] capacity;
	logic             cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_CAPACITY);
	assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

	bsa_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.st        (st),
		.ctl       (ctl)
	);

	bsa_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_command    (cmd.command),
		.in_slot_index (cmd.slot_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[CNT_W-1:0]),
		.capacity      (capacity),
		.ctl           (ctl),
		.st            (st),
		.res           (result)
	);

	assign res.status     = result.status;
	assign res.found      = result.found;
	assign res.free_slot  = result.free_slot;
	assign res.slot_used  = result.slot_used;
	assign res.used_count = result.used_count;

endmodule

// ===== hw/rtl/bsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_datapath
// occupancy word memory, used count, capacity register, word scan and results
// ----------------------------------------------------------------------------
module bsa_datapath import bsa_pkg::*; #(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CMD_W-1:0] in_command,
	input  logic [IDX_W-1:0] in_slot_index,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic [CNT_W-1:0] capacity,
	input  ctrl_cmd_t        ctl,
	output ctrl_stat_t       st,
	output result_t          res
);

	localparam int NWORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SW     = AW + WORD_SH;
	localparam int XW     = ((SW > CNT_W) ? SW : CNT_W) + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	logic [CNT_W-1:0]   capacity_q;
	logic [CNT_W-1:0]   count_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [AW-1:0]      scan_q;
	logic [WORD_W-1:0]  mem [NWORDS];
	logic [NWORDS-1:0]  wvalid_q;
	logic [WORD_W-1:0]  word_q;
	logic               word_ok_q;
	result_t            res_q;

	logic [CNT_W-1:0]   cap_eff;
	logic               in_range;
	logic [AW-1:0]      slot_word;
	logic [WORD_SH-1:0] bit_sel;
	logic [AW-1:0]      rd_addr;
	logic [WORD_W-1:0]  word_eff;
	logic [XW-1:0]      base_x;
	logic [XW-1:0]      rem_x;
	logic [WORD_W-1:0]  mask;
	logic [WORD_W-1:0]  free_vec;
	logic [WORD_SH-1:0] enc;
	logic               bit_cur;
	logic [WORD_W-1:0]  new_word;
	logic               do_write;
	logic [STAT_W-1:0]  slot_status;
	logic               slot_used;
	logic [CNT_W-1:0]   slot_count;
	logic               mem_we;
	logic               clear_all;
	result_t            res_d;
	logic [CNT_W-1:0]   count_d;

	assign cap_eff   = (int'(capacity_q) < MAX_SLOTS) ? capacity_q : CNT_W'(MAX_SLOTS);
	assign in_range  = CNT_W'(idx_q) < cap_eff;
	assign slot_word = AW'(idx_q >> WORD_SH);
	assign bit_sel   = idx_q[WORD_SH-1:0];
	assign word_eff  = word_ok_q ? word_q : '0;

	assign base_x = XW'({scan_q, {WORD_SH{1'b0}}});
	assign rem_x  = XW'(cap_eff) - base_x;

	always_comb begin
		if (rem_x >= XW'(WORD_W)) begin
			mask = '1;
		end else begin
			mask = ~({WORD_W{1'b1}} << rem_x[WORD_SH-1:0]);
		end
	end

	assign free_vec = ~word_eff & mask;

	always_comb begin
		enc = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				enc = WORD_SH'(b);
			end
		end
	end

	assign st.in_cmd = in_command;
	assign st.full   = count_q >= cap_eff;
	assign st.hit    = |free_vec;
	assign st.last   = (rem_x <= XW'(WORD_W)) || (scan_q == LAST_WORD);

	always_comb begin
		bit_cur     = word_eff[bit_sel];
		new_word    = word_eff;
		do_write    = 1'b0;
		slot_status = ST_OK;
		slot_used   = 1'b0;
		slot_count  = count_q;
		unique case (cmd_q)
			CMD_MARK_USED: begin
				if (!in_range) begin
					slot_status = ST_INVALID;
				end else if (count_q >= cap_eff) begin
					slot_status = ST_FULL;
				end else if (bit_cur) begin
					slot_status = ST_INVALID;
				end else begin
					new_word[bit_sel] = 1'b1;
					do_write          = 1'b1;
					slot_count        = count_q + CNT_W'(1);
				end
			end
			CMD_MARK_FREE: begin
				if (!in_range || (count_q == '0) || !bit_cur) begin
					slot_status = ST_INVALID;
				end else begin
					new_word[bit_sel] = 1'b0;
					do_write          = 1'b1;
					slot_count        = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (!in_range) begin
					slot_status = ST_INVALID;
				end else begin
					slot_used = bit_cur;
				end
			end
		endcase
	end

	assign mem_we    = ctl.load && (ctl.kind == RES_SLOT) && do_write;
	assign clear_all = ctl.load && (ctl.kind == RES_MISC) && (cmd_q == CMD_CLEAR);

	always_comb begin
		res_d            = '0;
		res_d.used_count = count_q;
		count_d          = count_q;
		unique case (ctl.kind)
			RES_FULL: begin
				res_d.status = ST_FULL;
			end
			RES_FIND: begin
				if (st.hit) begin
					res_d.status    = ST_OK;
					res_d.found     = 1'b1;
					res_d.free_slot = IDX_W'({scan_q, enc});
				end else begin
					res_d.status = ST_FULL;
				end
			end
			RES_SLOT: begin
				res_d.status     = slot_status;
				res_d.slot_used  = slot_used;
				res_d.used_count = slot_count;
				count_d          = slot_count;
			end
			RES_MISC: begin
				if (cmd_q == CMD_CLEAR) begin
					res_d.status     = ST_OK;
					res_d.used_count = '0;
					count_d          = '0;
				end else begin
					res_d.status = ST_INVALID;
				end
			end
		endcase
	end

	always_comb begin
		unique case (ctl.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_NEXT: rd_addr = scan_q + AW'(1);
			RD_SLOT: rd_addr = slot_word;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			count_q    <= '0;
			wvalid_q   <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (ctl.load) begin
				count_q <= count_d;
			end
			if (clear_all) begin
				wvalid_q <= '0;
			end else if (mem_we) begin
				wvalid_q[slot_word] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= in_command;
			idx_q <= in_slot_index;
		end
		if (ctl.scan_clr) begin
			scan_q <= '0;
		end else if (ctl.scan_inc) begin
			scan_q <= scan_q + AW'(1);
		end
		if (ctl.load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_word] <= new_word;
		end
		if (ctl.rd_en) begin
			word_q    <= mem[rd_addr];
			word_ok_q <= wvalid_q[rd_addr];
		end
	end

	assign capacity = capacity_q;
	assign res      = res_q;

endmodule

// ===== hw/rtl/bsa_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_controller
// command sequencer: dispatch, word scan, read-modify-write and result handoff
// ----------------------------------------------------------------------------
module bsa_controller import bsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ctrl_stat_t st,
	output ctrl_cmd_t  ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '{capture: 1'b0, rd_en: 1'b0, rd_sel: RD_ZERO, scan_clr: 1'b0,
			scan_inc: 1'b0, load: 1'b0, kind: RES_MISC};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					if (st.in_cmd == CMD_FIND) begin
						state_d = S_FIND_RD;
					end else if ((st.in_cmd == CMD_MARK_USED) || (st.in_cmd == CMD_MARK_FREE)
						|| (st.in_cmd == CMD_QUERY)) begin
						state_d = S_SLOT_RD;
					end else begin
						state_d = S_MISC;
					end
				end
			end
			S_FIND_RD: begin
				if (st.full) begin
					ctl.kind = RES_FULL;
					if (out_free) begin
						ctl.load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.rd_en    = 1'b1;
					ctl.rd_sel   = RD_ZERO;
					ctl.scan_clr = 1'b1;
					state_d      = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				ctl.kind = RES_FIND;
				if (st.hit || st.last) begin
					if (out_free) begin
						ctl.load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.rd_en    = 1'b1;
					ctl.rd_sel   = RD_NEXT;
					ctl.scan_inc = 1'b1;
				end
			end
			S_SLOT_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_SLOT;
				state_d    = S_SLOT_EXEC;
			end
			S_SLOT_EXEC: begin
				ctl.kind = RES_SLOT;
				if (out_free) begin
					ctl.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_MISC: begin
				ctl.kind = RES_MISC;
				if (out_free) begin
					ctl.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start work");

	a_no_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !ctl.load)
		else $error("result loaded in the cycle a transaction was accepted");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_rose_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.load))
		else $error("result valid without a load");

	a_read_or_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> !ctl.load)
		else $error("memory read issued while a result is loaded");

endmodule
